>>> design/rgbm_pkg.sv
// Shared types and constants of the RGBM pixel encoder.
`default_nettype none
package rgbm_pkg;

	// Fixed-point format of the HDR channels
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned CH_W      = 24;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SHIFT_W   = 4;
	localparam int unsigned LANES     = 3;

	// Rate shift after reset: divide by 16
	localparam logic [SHIFT_W-1:0] RATE_SHIFT_RST = SHIFT_W'(4);

	// Clamped channel maximum holds 1 .. 2^FRAC_BITS
	localparam int unsigned MX_W = FRAC_BITS + 1;
	localparam logic [MX_W-1:0] UNIT_ONE = MX_W'(1) << FRAC_BITS;

	// 255 and 255*255
	localparam int unsigned SQ_W = 16;
	localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
	localparam logic [SQ_W-1:0]   SQ_255   = SQ_W'(65025);

	// Dividend 2*c*65025 + m8*ONE and its part above the 2*ONE factor of the divisor
	localparam int unsigned PROD_W = CH_W + 1 + SQ_W;
	localparam int unsigned NUM_W  = PROD_W + 1;
	localparam int unsigned REM_W  = NUM_W - (FRAC_BITS + 1);

	// Divisor m8 aligned to the top quotient bit (the overflow bit)
	localparam int unsigned DSH_W = 2 * BYTE_W;
	localparam int unsigned CELLS = BYTE_W + 1;

	// Pipeline registers between accepted item and result strobe: three front stages, cells, output
	localparam int unsigned LATENCY = 3 + CELLS + 1;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red_out;
		logic [BYTE_W-1:0] green_out;
		logic [BYTE_W-1:0] blue_out;
		logic [BYTE_W-1:0] multiplier_out;
	} result_t;

	// One item in flight through the divider row
	typedef struct packed {
		logic                         vld;
		logic [LANES-1:0][REM_W-1:0]  rem;
		logic [LANES-1:0][CELLS-1:0]  quo;
		logic [DSH_W-1:0]             dsh;
		logic [BYTE_W-1:0]            m8;
	} cell_t;

endpackage
`default_nettype wire

>>> design/rgbm_front.sv
// Front pipeline: range shift, shared multiplier code and per-channel dividends.
`default_nettype none
module rgbm_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  wire rgbm_pkg::pixel_t                pixel,
	input  wire logic [rgbm_pkg::SHIFT_W-1:0]    rate_shift,
	output rgbm_pkg::cell_t                      head
);

	localparam int unsigned CMP_W = rgbm_pkg::CH_W + 1;
	localparam int unsigned M_W   = rgbm_pkg::MX_W + rgbm_pkg::BYTE_W;

	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::CH_W-1:0] ch_in;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::CH_W-1:0] sh;
	logic [rgbm_pkg::CH_W-1:0]                      mx_raw;
	logic [rgbm_pkg::MX_W-1:0]                      mx_cl;

	logic                                            vld_s1, vld_s2, vld_s3;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::CH_W-1:0] ch_s1;
	logic [rgbm_pkg::MX_W-1:0]                      mx_s1;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::PROD_W-1:0] prod_s2;
	logic [rgbm_pkg::BYTE_W-1:0]                    m8_s2;
	logic [M_W-1:0]                                  m8_wide;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::REM_W-1:0] rem_s3;
	logic [rgbm_pkg::BYTE_W-1:0]                    m8_s3;

	assign ch_in[0] = pixel.red_in;
	assign ch_in[1] = pixel.green_in;
	assign ch_in[2] = pixel.blue_in;

	// Range shift and channel maximum, clamped to one LSB .. 1.0
	always_comb begin
		for (int i = 0; i < rgbm_pkg::LANES; i++) begin
			sh[i] = ch_in[i] >> rate_shift;
		end
		mx_raw = sh[0];
		if (sh[1] > mx_raw) begin
			mx_raw = sh[1];
		end
		if (sh[2] > mx_raw) begin
			mx_raw = sh[2];
		end
		if (mx_raw == '0) begin
			mx_cl = rgbm_pkg::MX_W'(1);
		end else if (CMP_W'(mx_raw) > CMP_W'(rgbm_pkg::UNIT_ONE)) begin
			mx_cl = rgbm_pkg::UNIT_ONE;
		end else begin
			mx_cl = rgbm_pkg::MX_W'(mx_raw);
		end
	end

	// m8 = ceil(mx * 255 / ONE)
	assign m8_wide = M_W'(mx_s1) * M_W'(rgbm_pkg::BYTE_MAX)
		+ M_W'(rgbm_pkg::UNIT_ONE - rgbm_pkg::MX_W'(1));

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		// s1: shifted channels and clamped maximum
		ch_s1 <= sh;
		mx_s1 <= mx_cl;
		// s2: multiplier code and 2*c*65025 per channel
		m8_s2 <= rgbm_pkg::BYTE_W'(m8_wide >> rgbm_pkg::FRAC_BITS);
		for (int i = 0; i < rgbm_pkg::LANES; i++) begin
			prod_s2[i] <= rgbm_pkg::PROD_W'({ch_s1[i], 1'b0})
				* rgbm_pkg::PROD_W'(rgbm_pkg::SQ_255);
		end
		// s3: rounding term added, divisor factor 2*ONE taken off
		m8_s3 <= m8_s2;
		for (int i = 0; i < rgbm_pkg::LANES; i++) begin
			rem_s3[i] <= rgbm_pkg::REM_W'((rgbm_pkg::NUM_W'(prod_s2[i])
				+ (rgbm_pkg::NUM_W'(m8_s2) << rgbm_pkg::FRAC_BITS))
				>> (rgbm_pkg::FRAC_BITS + 1));
		end
	end

	// Hand-off to the first divider cell
	always_comb begin
		head.vld = vld_s3;
		head.rem = rem_s3;
		head.quo = '0;
		head.dsh = rgbm_pkg::DSH_W'(m8_s3) << rgbm_pkg::BYTE_W;
		head.m8  = m8_s3;
	end

endmodule
`default_nettype wire

>>> design/rgbm_div_cell.sv
// One restoring-division step for all three channels, registered.
`default_nettype none
module rgbm_div_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rgbm_pkg::cell_t  d,
	output rgbm_pkg::cell_t       q
);

	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::REM_W-1:0] rem_nx;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::CELLS-1:0] quo_nx;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::REM_W-1:0] rem_q;
	logic [rgbm_pkg::LANES-1:0][rgbm_pkg::CELLS-1:0] quo_q;
	logic [rgbm_pkg::DSH_W-1:0]                      dsh_q;
	logic [rgbm_pkg::BYTE_W-1:0]                     m8_q;
	logic                                            vld_q;
	logic [rgbm_pkg::REM_W-1:0]                      dsh_ext;

	assign dsh_ext = rgbm_pkg::REM_W'(d.dsh);

	// Compare, subtract, shift in the quotient bit
	always_comb begin
		for (int i = 0; i < rgbm_pkg::LANES; i++) begin
			if (d.rem[i] >= dsh_ext) begin
				rem_nx[i] = d.rem[i] - dsh_ext;
				quo_nx[i] = {d.quo[i][rgbm_pkg::CELLS-2:0], 1'b1};
			end else begin
				rem_nx[i] = d.rem[i];
				quo_nx[i] = {d.quo[i][rgbm_pkg::CELLS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_nx;
		quo_q <= quo_nx;
		dsh_q <= d.dsh >> 1;
		m8_q  <= d.m8;
	end

	always_comb begin
		q.vld = vld_q;
		q.rem = rem_q;
		q.quo = quo_q;
		q.dsh = dsh_q;
		q.m8  = m8_q;
	end

endmodule
`default_nettype wire

>>> design/rgbm_pixel_encoder.sv
// RGBM pixel encoder top level: front pipeline, divider cell row, result register.
//
//  channel   signals                        direction  handshake
//  --------  -----------------------------  ---------  ---------------------------
//  pixel     start, busy, pixel             in         taken when start && !busy
//  result    done, result                   out        one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_data in         write when valid && ready
//
//  One item per clock. Stages: three front stages (shift and maximum, multiplies,
//  dividend), nine divider cells (overflow bit plus eight quotient bits), one result
//  register. busy stays low: nothing holds the row.
//  Reset clears all valid bits and sets rate_shift to 4; no clearing pass.
//  The result side cannot stall, so no item is ever held back in the row.
`default_nettype none
module rgbm_pixel_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rgbm_pkg::pixel_t              pixel,
	output logic                               done,
	output rgbm_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rgbm_pkg::SHIFT_W-1:0]  cfg_data
);

	logic [rgbm_pkg::SHIFT_W-1:0] rate_shift_q;
	logic                         take;
	rgbm_pkg::cell_t              chain [rgbm_pkg::CELLS+1];
	rgbm_pkg::cell_t              tail;
	rgbm_pkg::result_t            res_nx;
	rgbm_pkg::result_t            result_q;
	logic                         done_q;

	// Fully pipelined: always ready for an item and a config write
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	// Rate shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_shift_q <= rgbm_pkg::RATE_SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			rate_shift_q <= cfg_data;
		end
	end

	rgbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel      (pixel),
		.rate_shift (rate_shift_q),
		.head       (chain[0])
	);

	// Divider row, one quotient bit per cell
	for (genvar k = 0; k < rgbm_pkg::CELLS; k++) begin : g_cell
		rgbm_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[k]),
			.q      (chain[k+1])
		);
	end

	assign tail = chain[rgbm_pkg::CELLS];

	// Saturate on the overflow bit
	always_comb begin
		if (tail.quo[0][rgbm_pkg::CELLS-1]) begin
			res_nx.red_out = rgbm_pkg::BYTE_MAX;
		end else begin
			res_nx.red_out = tail.quo[0][rgbm_pkg::BYTE_W-1:0];
		end
		if (tail.quo[1][rgbm_pkg::CELLS-1]) begin
			res_nx.green_out = rgbm_pkg::BYTE_MAX;
		end else begin
			res_nx.green_out = tail.quo[1][rgbm_pkg::BYTE_W-1:0];
		end
		if (tail.quo[2][rgbm_pkg::CELLS-1]) begin
			res_nx.blue_out = rgbm_pkg::BYTE_MAX;
		end else begin
			res_nx.blue_out = tail.quo[2][rgbm_pkg::BYTE_W-1:0];
		end
		res_nx.multiplier_out = tail.m8;
	end

	// Result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nx;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

>>> design/rgbm_checker.sv
// Port-level checks of the RGBM pixel encoder and their binding.
`default_nettype none
module rgbm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire rgbm_pkg::pixel_t  pixel,
	input wire logic              done,
	input wire rgbm_pkg::result_t result,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);

	// Every accepted item shows up after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rgbm_pkg::LATENCY) done)
		else $error("accepted item produced no result");

	// No result without a matching accepted item
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(rgbm_pkg::LATENCY) !done)
		else $error("result without accepted item");

	// Multiplier code is never zero
	a_m8_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.multiplier_out != '0))
		else $error("multiplier code zero");

	// A black pixel encodes to zero bytes with code one
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (pixel == '0), rgbm_pkg::LATENCY))
		|-> (result.multiplier_out == 8'd1 && result.red_out == '0
			&& result.green_out == '0 && result.blue_out == '0))
		else $error("black pixel encoded wrong");

	// Config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write held off");

endmodule

bind rgbm_pixel_encoder rgbm_checker u_rgbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.pixel     (pixel),
	.done      (done),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the RGBM pixel encoder: directed corners, then random pixels.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam logic [63:0] ONE_FX = 64'(1) << rgbm_pkg::FRAC_BITS;
	localparam int unsigned ITEMS_PER_SETTING = 45;
	localparam int unsigned DUE_DEPTH = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rgbm_pkg::pixel_t pixel = '0;
	logic done;
	rgbm_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rgbm_pkg::SHIFT_W-1:0] cfg_data = '0;

	// Model copy of the range shift and the encodings still owed by the block
	logic [rgbm_pkg::SHIFT_W-1:0] shift_model = rgbm_pkg::RATE_SHIFT_RST;
	rgbm_pkg::result_t due_mem [DUE_DEPTH];
	int unsigned due_wr = 0;
	int unsigned due_rd = 0;
	int unsigned mismatches = 0;
	int unsigned idle_pct = 0;
	int unsigned stalled_cycles = 0;

	rgbm_pixel_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// RGBM encoding of one pixel under a given range shift
	function automatic rgbm_pkg::result_t encode_pixel(rgbm_pkg::pixel_t p,
		logic [rgbm_pkg::SHIFT_W-1:0] sh);
		logic [63:0] lane [3];
		logic [63:0] peak;
		logic [63:0] m8;
		logic [63:0] quot;
		logic [7:0] bytes [3];
		rgbm_pkg::result_t r;
		lane[0] = 64'(p.red_in) >> sh;
		lane[1] = 64'(p.green_in) >> sh;
		lane[2] = 64'(p.blue_in) >> sh;
		peak = lane[0];
		if (lane[1] > peak) peak = lane[1];
		if (lane[2] > peak) peak = lane[2];
		if (peak < 1) peak = 1;
		if (peak > ONE_FX) peak = ONE_FX;
		m8 = (peak * 255 + ONE_FX - 1) / ONE_FX;
		if (m8 < 1) m8 = 1;
		if (m8 > 255) m8 = 255;
		for (int i = 0; i < 3; i++) begin
			quot = (2 * lane[i] * 65025 + m8 * ONE_FX) / (2 * m8 * ONE_FX);
			bytes[i] = (quot > 255) ? 8'd255 : quot[7:0];
		end
		r.red_out = bytes[0];
		r.green_out = bytes[1];
		r.blue_out = bytes[2];
		r.multiplier_out = m8[7:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every result strobe with the oldest owed encoding
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_wr == due_rd) begin
				$error("result with no item outstanding");
				mismatches++;
			end else begin
				rgbm_pkg::result_t want;
				want = due_mem[due_rd % DUE_DEPTH];
				due_rd++;
				check_field("red_out", want.red_out, result.red_out);
				check_field("green_out", want.green_out, result.green_out);
				check_field("blue_out", want.blue_out, result.blue_out);
				check_field("multiplier_out", want.multiplier_out, result.multiplier_out);
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Send one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(input logic [rgbm_pkg::CH_W-1:0] r, g, b);
		rgbm_pkg::pixel_t p;
		p.red_in = r;
		p.green_in = g;
		p.blue_in = b;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		due_mem[due_wr % DUE_DEPTH] = encode_pixel(p, shift_model);
		due_wr++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (due_wr != due_rd) @(posedge clk);
	endtask

	// Register write only once the pipeline has emptied
	task automatic write_rate_shift(input logic [rgbm_pkg::SHIFT_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shift_model = value;
	endtask

	// Random channel confined to a number of low bits
	function automatic logic [rgbm_pkg::CH_W-1:0] rand_channel(int unsigned bits);
		return rgbm_pkg::CH_W'($urandom) & ((rgbm_pkg::CH_W'(1) << bits) - 1);
	endfunction

	// Reset shift: zero pixel, full scale, exactly 1.0, one LSB and just below one LSB after the shift
	task automatic test_reset_shift();
		send_pixel(24'h000000, 24'h000000, 24'h000000);
		send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(24'h100000, 24'h000000, 24'h000000);
		send_pixel(24'h000000, 24'h000010, 24'h000000);
		send_pixel(24'h000000, 24'h000000, 24'h00000F);
	endtask

	// No shift: zero, LSB, exact 1.0, just above 1.0, half level, bit patterns, full scale
	task automatic test_no_shift();
		write_rate_shift(rgbm_pkg::SHIFT_W'(0));
		send_pixel(24'h000000, 24'h000000, 24'h000000);
		send_pixel(24'h000001, 24'h000000, 24'h000000);
		send_pixel(24'h000000, 24'h010000, 24'h000000);
		send_pixel(24'h000000, 24'h000000, 24'h010001);
		send_pixel(24'h008000, 24'h008000, 24'h008000);
		send_pixel(24'hAAAAAA, 24'h555555, 24'h000000);
		send_pixel(24'h555555, 24'hAAAAAA, 24'hFFFFFF);
		send_pixel(24'h0000FF, 24'h000100, 24'h000101);
		send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
	endtask

	// Largest legal shift and a shift above the legal range
	task automatic test_wide_shifts();
		write_rate_shift(rgbm_pkg::SHIFT_W'(8));
		send_pixel(24'hFFFFFF, 24'h800000, 24'h000000);
		send_pixel(24'h0000FF, 24'h0000FF, 24'h0000FF);
		write_rate_shift(rgbm_pkg::SHIFT_W'(15));
		send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(24'h007FFF, 24'h008000, 24'hFFFFFF);
	endtask

	// Random pixels in several idle phases, a new shift every few dozen items
	task automatic test_random_pixels();
		int unsigned phase_idle [3] = '{0, 47, 17};
		int unsigned bits;
		logic [rgbm_pkg::SHIFT_W-1:0] sh;
		for (int ph = 0; ph < 3; ph++) begin
			for (int blk = 0; blk < 3; blk++) begin
				idle_pct = 0;
				if ($urandom_range(9) == 0)
					sh = rgbm_pkg::SHIFT_W'($urandom_range(15, 9));
				else
					sh = rgbm_pkg::SHIFT_W'($urandom_range(8));
				write_rate_shift(sh);
				idle_pct = phase_idle[ph];
				for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
					// Mostly channels scaled around 1.0 after the shift, some full range
					if ($urandom_range(3) == 0)
						bits = rgbm_pkg::CH_W;
					else
						bits = $urandom_range(
							(rgbm_pkg::FRAC_BITS + sh + 1 > rgbm_pkg::CH_W) ?
							rgbm_pkg::CH_W : rgbm_pkg::FRAC_BITS + sh + 1, 1);
					case ($urandom_range(4))
						0: send_pixel(rand_channel(bits), 24'h000000, rand_channel(bits));
						1: send_pixel(24'h000000, rand_channel(bits), rand_channel(bits));
						default: send_pixel(rand_channel(bits), rand_channel(bits),
							rand_channel(bits));
					endcase
				end
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_shift();
		test_no_shift();
		test_wide_shifts();
		test_random_pixels();
		wait_drained();
		repeat (rgbm_pkg::LATENCY + 2) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
